// ===== design/apdq_pkg.sv =====
package apdq_pkg;

	localparam int TAG_W     = 8;
	localparam int LEVEL_W   = 3;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int PEND_W    = 9;
	localparam int INFL_W    = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_LOW = '0;

	localparam logic [CFG_W-1:0] MAX_IN_FLIGHT_RST = 8'd4;
	localparam logic [CFG_W-1:0] PRIO_MULT_RST     = 8'd10;
	localparam logic             AGING_EN_RST      = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_IN_FLIGHT = 2'd0,
		CFG_PRIO_MULT     = 2'd1,
		CFG_AGING_EN      = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		FUNC_ENQUEUE  = 1'b0,
		FUNC_COMPLETE = 1'b1
	} func_t;

	typedef struct packed {
		logic step;
		logic ins;
		logic tail;
		logic dispatch;
		logic aging_en;
	} ctrl_t;

endpackage

// ===== design/apdq_if.sv =====
interface apdq_in_if;
	import apdq_pkg::*;
	logic               valid;
	logic               ready;
	logic               func;
	logic [TAG_W-1:0]   request_tag;
	logic [LEVEL_W-1:0] priority_level;
	modport source(output valid, func, request_tag, priority_level, input ready);
	modport sink(input valid, func, request_tag, priority_level, output ready);
endinterface

interface apdq_out_if;
	import apdq_pkg::*;
	logic              valid;
	logic              ready;
	logic              dispatch_valid;
	logic [TAG_W-1:0]  dispatch_tag;
	logic              rejected;
	logic [PEND_W-1:0] pending_count;
	logic [INFL_W-1:0] in_flight_count;
	modport source(output valid, dispatch_valid, dispatch_tag, rejected, pending_count,
		in_flight_count, input ready);
	modport sink(input valid, dispatch_valid, dispatch_tag, rejected, pending_count,
		in_flight_count, output ready);
endinterface

interface apdq_cfg_if;
	import apdq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/apdq_cell.sv =====
module apdq_cell #(
	parameter int KEY_WIDTH = 16
) (
	input  logic                       clk,
	input  apdq_pkg::ctrl_t            ctrl,
	input  logic                       occ,
	input  logic                       before_in,
	output logic                       before_out,
	input  logic [apdq_pkg::TAG_W-1:0] new_tag,
	input  logic [KEY_WIDTH-1:0]       new_key,
	input  logic [apdq_pkg::TAG_W-1:0] left_tag,
	input  logic [KEY_WIDTH-1:0]       left_key,
	input  logic [apdq_pkg::TAG_W-1:0] right_tag,
	input  logic [KEY_WIDTH-1:0]       right_key,
	output logic [apdq_pkg::TAG_W-1:0] post_tag,
	output logic [KEY_WIDTH-1:0]       post_key,
	output logic [apdq_pkg::TAG_W-1:0] tag,
	output logic [KEY_WIDTH-1:0]       key
);
	import apdq_pkg::*;

	logic [TAG_W-1:0]     tag_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] aged_key;

	assign tag = tag_q;
	assign key = key_q;

	// With aging enabled, an entry pushed back by an insert ages by one, saturating at the key maximum.
	assign aged_key = (ctrl.aging_en && (left_key != '1)) ? left_key + 1'b1 : left_key;

	assign before_out = !ctrl.ins || (before_in && occ && (ctrl.tail || (key_q >= new_key)));

	always_comb begin
		if (before_out) begin
			post_tag = tag_q;
			post_key = key_q;
		end else if (before_in) begin
			post_tag = new_tag;
			post_key = new_key;
		end else begin
			post_tag = left_tag;
			post_key = aged_key;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (ctrl.dispatch) begin
				tag_q <= right_tag;
				key_q <= right_key;
			end else begin
				tag_q <= post_tag;
				key_q <= post_key;
			end
		end
	end

endmodule

// ===== design/aging_priority_dispatch_queue.sv =====
// Bounded priority queue of request tags built as a row of cells, one per entry, that
// dispatches from its head while fewer than max_in_flight requests are outstanding.
// An item is taken in every cycle in which the output register is empty or being read,
// and its result appears in the output register on the next cycle, so one item per
// cycle is sustained. The insert position search ripples through the cell row and the
// whole row shifts in the same cycle, which sets the clock period for deep queues.
// Configuration writes are always accepted and must only be issued while idle.
module aging_priority_dispatch_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_WIDTH   = 16
) (
	input logic        clk,
	input logic        arst_n,
	apdq_in_if.sink    req,
	apdq_out_if.source rsp,
	apdq_cfg_if.sink   cfg
);
	import apdq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CFG_W-1:0]  max_in_flight_q;
	logic [CFG_W-1:0]  prio_mult_q;
	logic              aging_en_q;
	logic [CNT_W-1:0]  count_q;
	logic [INFL_W-1:0] in_flight_q;

	logic              out_valid_q;
	logic              dispatch_valid_q;
	logic [TAG_W-1:0]  dispatch_tag_q;
	logic              rejected_q;
	logic [PEND_W-1:0] pending_count_q;
	logic [INFL_W-1:0] in_flight_count_q;

	logic                     accept;
	logic                     is_enq;
	logic                     full;
	logic                     disp;
	logic [INFL_W-1:0]        inf_dec;
	logic [INFL_W-1:0]        inf_next;
	logic [CNT_W-1:0]         count_ins;
	logic [CNT_W-1:0]         count_next;
	logic [LEVEL_W+CFG_W-1:0] prod;
	logic [KEY_WIDTH-1:0]     new_key;
	ctrl_t                    ctrl;

	logic [TAG_W-1:0]     tag_a    [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0] key_a    [QUEUE_DEPTH];
	logic [TAG_W-1:0]     post_tag [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0] post_key [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] bchain;

	assign accept    = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign is_enq    = (req.func == FUNC_ENQUEUE);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign inf_dec   = (!is_enq && (in_flight_q != '0)) ? in_flight_q - 1'b1 : in_flight_q;
	assign count_ins = count_q + CNT_W'(is_enq && !full);
	assign disp      = (inf_dec < max_in_flight_q) && (count_ins != '0);
	assign count_next = count_ins - CNT_W'(disp);
	assign inf_next   = inf_dec + INFL_W'(disp);

	assign prod    = {{CFG_W{1'b0}}, req.priority_level} * {{LEVEL_W{1'b0}}, prio_mult_q};
	assign new_key = KEY_WIDTH'(prod);

	assign ctrl.step     = accept;
	assign ctrl.ins      = accept && is_enq && !full;
	assign ctrl.tail     = (req.priority_level == LEVEL_LOW);
	assign ctrl.dispatch = disp;
	assign ctrl.aging_en = aging_en_q;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 occ;
		logic                 before_in;
		logic [TAG_W-1:0]     left_tag;
		logic [KEY_WIDTH-1:0] left_key;
		logic [TAG_W-1:0]     right_tag;
		logic [KEY_WIDTH-1:0] right_key;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign before_in = 1'b1;
			assign left_tag  = '0;
			assign left_key  = '0;
		end else begin : g_body
			assign before_in = bchain[i-1];
			assign left_tag  = tag_a[i-1];
			assign left_key  = key_a[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_tag = '0;
			assign right_key = '0;
		end else begin : g_inner
			assign right_tag = post_tag[i+1];
			assign right_key = post_key[i+1];
		end

		apdq_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ),
			.before_in (before_in),
			.before_out(bchain[i]),
			.new_tag   (req.request_tag),
			.new_key   (new_key),
			.left_tag  (left_tag),
			.left_key  (left_key),
			.right_tag (right_tag),
			.right_key (right_key),
			.post_tag  (post_tag[i]),
			.post_key  (post_key[i]),
			.tag       (tag_a[i]),
			.key       (key_a[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_in_flight_q <= MAX_IN_FLIGHT_RST;
			prio_mult_q     <= PRIO_MULT_RST;
			aging_en_q      <= AGING_EN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MAX_IN_FLIGHT: max_in_flight_q <= cfg.data;
				CFG_PRIO_MULT:     prio_mult_q     <= cfg.data;
				CFG_AGING_EN:      aging_en_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			in_flight_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				in_flight_q <= inf_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dispatch_valid_q  <= disp;
			dispatch_tag_q    <= disp ? post_tag[0] : '0;
			rejected_q        <= is_enq && full;
			pending_count_q   <= PEND_W'(count_next) + PEND_W'(inf_next);
			in_flight_count_q <= inf_next;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.dispatch_valid  = dispatch_valid_q;
	assign rsp.dispatch_tag    = dispatch_tag_q;
	assign rsp.rejected        = rejected_q;
	assign rsp.pending_count   = pending_count_q;
	assign rsp.in_flight_count = in_flight_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |-> !bchain[QUEUE_DEPTH-1])
		else $error("insert found no free cell");

	a_dispatch_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && disp) |=> (in_flight_q != '0) && rsp.valid)
		else $error("dispatch did not raise in-flight count");
`endif

endmodule
